>>> design/assert_macros.svh
// Assertion macros used by the top level of the CNN cell update block.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CNNU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CNNU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CNNU_ASSERT_IMPL(label, ante, cons, msg)
`define CNNU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> design/cnnu_pkg.sv
// Shared types, constants and helpers for the CNN 3x3 template RK4 cell update.
// Depends on nothing; the front, queue, back and top level files use it.
package cnnu_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int VALUE_BITS    = 16;
  localparam int BORDER        = 1;
  localparam int MAX_HEIGHT    = 4096;
  localparam int COL_W         = 11;
  localparam int ROW_W         = 12;
  localparam int HELD_W        = 27;
  localparam int CTR_W         = 32;
  localparam int ACC_W         = 35;
  localparam int Q_DEPTH       = 8;
  localparam int Q_AW          = 3;
  localparam int ADDR_W        = 6;
  localparam int DATA_W        = 64;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_A_UPPER     = 3'd0;
  localparam reg_idx_t REG_A_LOWER     = 3'd1;
  localparam reg_idx_t REG_B_UPPER     = 3'd2;
  localparam reg_idx_t REG_B_LOWER     = 3'd3;
  localparam reg_idx_t REG_BIAS        = 3'd4;
  localparam reg_idx_t REG_TIME_STEP   = 3'd5;
  localparam reg_idx_t REG_GRID_WIDTH  = 3'd6;
  localparam reg_idx_t REG_GRID_HEIGHT = 3'd7;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] state_value;
    logic signed [VALUE_BITS-1:0] drive_value;
  } in_item_t;

  typedef struct packed {
    logic signed [13:0] next_value;
    logic               frame_done;
  } out_item_t;

  typedef struct packed {
    logic [47:0]        a_upper;
    logic [23:0]        a_lower;
    logic [47:0]        b_upper;
    logic [23:0]        b_lower;
    logic signed [15:0] bias;
    logic [15:0]        time_step;
    logic [10:0]        grid_width;
    logic [12:0]        grid_height;
  } cfg_t;

  // One classified cell handed from the front to the back.
  typedef struct packed {
    logic signed [HELD_W-1:0]     held;
    logic signed [VALUE_BITS-1:0] center;
    logic                         frame_done;
  } work_t;

  function automatic logic signed [7:0] tap(input logic [47:0] up, input logic [23:0] lo,
                                            input int i);
    logic [7:0] b;
    if (i < 6) begin
      b = up[8*i +: 8];
    end else begin
      b = lo[8*(i-6) +: 8];
    end
    return $signed(b);
  endfunction

endpackage

>>> design/cnnu_front.sv
// Front end: raster tracking, line stores, 3x3 windows and the held part of the derivative.
// Depends on cnnu_pkg.
module cnnu_front #(
  parameter int MAX_WIDTH = cnnu_pkg::MAX_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  cnnu_pkg::in_item_t      in_data,
  input  cnnu_pkg::cfg_t          cfg,
  input  logic [cnnu_pkg::Q_AW:0] q_count,
  output logic                    q_push,
  output cnnu_pkg::work_t         q_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW = cnnu_pkg::HELD_W;

  logic                        acc;
  logic [cnnu_pkg::COL_W-1:0]  col_r;
  logic [cnnu_pkg::ROW_W-1:0]  row_r;
  logic [31:0]                 w_eff;
  logic [31:0]                 h_eff;
  logic [31:0]                 ci;
  logic                        end_row;
  logic                        end_frame;
  logic                        emit;
  logic [AW-1:0]               idx;

  logic [31:0]                 line0_mem [MAX_WIDTH];
  logic [31:0]                 line1_mem [MAX_WIDTH];
  logic [31:0]                 rd0_r;
  logic [31:0]                 rd1_r;

  logic                        s1_v_r;
  logic                        s1_emit_r;
  logic                        s1_done_r;
  logic [AW-1:0]               s1_idx_r;
  logic signed [15:0]          s1_sv_r;
  logic signed [15:0]          s1_dv_r;

  logic signed [15:0]          swin_r [9];
  logic signed [15:0]          dwin_r [9];
  logic                        s2_v_r;
  logic                        s2_done_r;

  logic signed [23:0]          ma [9];
  logic signed [23:0]          mb [9];
  logic signed [17:0]          pa_r [9];
  logic signed [23:0]          pb_r [9];
  logic signed [15:0]          s3_x_r;
  logic                        s3_v_r;
  logic                        s3_done_r;

  logic signed [HW-1:0]        part_r [3];
  logic signed [15:0]          s4_x_r;
  logic                        s4_v_r;
  logic                        s4_done_r;
  logic [2:0]                  inflight;

  // Items already in the pipe reserve their queue slot before the next one enters.
  assign inflight = {2'b0, s1_v_r} + {2'b0, s2_v_r} + {2'b0, s3_v_r} + {2'b0, s4_v_r};
  assign full = (32'(q_count) + 32'(inflight)) >= 32'(cnnu_pkg::Q_DEPTH);
  assign acc = push && !full;

  always_comb begin
    if (cfg.grid_width < 11'd3) begin
      w_eff = 32'd3;
    end else if (32'(cfg.grid_width) > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = 32'(cfg.grid_width);
    end
    if (cfg.grid_height < 13'd3) begin
      h_eff = 32'd3;
    end else if (32'(cfg.grid_height) > 32'(cnnu_pkg::MAX_HEIGHT)) begin
      h_eff = 32'(cnnu_pkg::MAX_HEIGHT);
    end else begin
      h_eff = 32'(cfg.grid_height);
    end
    end_row   = 32'(col_r) >= (w_eff - 32'd1);
    end_frame = end_row && (32'(row_r) >= (h_eff - 32'd1));
    emit      = (32'(row_r) >= 32'(2 * cnnu_pkg::BORDER)) &&
                (32'(col_r) >= 32'(2 * cnnu_pkg::BORDER));
    ci        = (32'(col_r) < 32'(MAX_WIDTH)) ? 32'(col_r) : 32'(MAX_WIDTH - 1);
    idx       = ci[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (end_frame) begin
        col_r <= '0;
        row_r <= '0;
      end else if (end_row) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // Line stores: read on transfer, rotate and write in the cycle after.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd0_r <= line0_mem[idx];
      rd1_r <= line1_mem[idx];
    end
    if (s1_v_r) begin
      line0_mem[s1_idx_r] <= {s1_sv_r, s1_dv_r};
      line1_mem[s1_idx_r] <= rd0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r && s1_emit_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_emit_r <= emit;
    s1_done_r <= end_frame;
    s1_idx_r  <= idx;
    s1_sv_r   <= in_data.state_value;
    s1_dv_r   <= in_data.drive_value;
    if (s1_v_r) begin
      for (int r = 0; r < 3; r++) begin
        swin_r[3*r]   <= swin_r[3*r+1];
        swin_r[3*r+1] <= swin_r[3*r+2];
        dwin_r[3*r]   <= dwin_r[3*r+1];
        dwin_r[3*r+1] <= dwin_r[3*r+2];
      end
      swin_r[2] <= rd1_r[31:16];
      swin_r[5] <= rd0_r[31:16];
      swin_r[8] <= s1_sv_r;
      dwin_r[2] <= rd1_r[15:0];
      dwin_r[5] <= rd0_r[15:0];
      dwin_r[8] <= s1_dv_r;
    end
    s2_done_r <= s1_done_r;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ma[i] = swin_r[i] * cnnu_pkg::tap(cfg.a_upper, cfg.a_lower, i);
      mb[i] = dwin_r[i] * cnnu_pkg::tap(cfg.b_upper, cfg.b_lower, i);
    end
  end

  // The center feedback term is left to the back end; the others are clipped here.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      if (i == 4) begin
        pa_r[i] <= '0;
      end else if (ma[i] > 24'sd65536) begin
        pa_r[i] <= 18'sd65536;
      end else if (ma[i] < -24'sd65536) begin
        pa_r[i] <= -18'sd65536;
      end else begin
        pa_r[i] <= ma[i][17:0];
      end
      pb_r[i] <= mb[i];
    end
    s3_x_r    <= swin_r[4];
    s3_done_r <= s2_done_r;
    for (int r = 0; r < 3; r++) begin
      part_r[r] <= HW'(pa_r[3*r]) + HW'(pa_r[3*r+1]) + HW'(pa_r[3*r+2]) +
                   HW'(pb_r[3*r]) + HW'(pb_r[3*r+1]) + HW'(pb_r[3*r+2]);
    end
    s4_x_r    <= s3_x_r;
    s4_done_r <= s3_done_r;
  end

  assign q_push            = s4_v_r;
  assign q_data.held       = (HW'(cfg.bias) <<< 4) + part_r[0] + part_r[1] + part_r[2];
  assign q_data.center     = s4_x_r;
  assign q_data.frame_done = s4_done_r;

endmodule

>>> design/cnnu_queue.sv
// Short queue of classified cells between the front and the back end.
// Depends on cnnu_pkg.
module cnnu_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_push,
  input  cnnu_pkg::work_t         q_wdata,
  input  logic                    q_pop,
  output cnnu_pkg::work_t         q_rdata,
  output logic                    q_empty,
  output logic [cnnu_pkg::Q_AW:0] q_count
);

  cnnu_pkg::work_t               slot_r [cnnu_pkg::Q_DEPTH];
  logic [cnnu_pkg::Q_AW-1:0]     wr_ptr_r;
  logic [cnnu_pkg::Q_AW-1:0]     rd_ptr_r;
  logic [cnnu_pkg::Q_AW:0]       count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (q_push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (q_pop && !q_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wr_ptr_r] <= q_wdata;
    end
  end

  assign q_rdata = slot_r[rd_ptr_r];
  assign q_empty = (count_r == '0);
  assign q_count = count_r;

endmodule

>>> design/cnnu_back.sv
// Back end: four RK4 stages on one shared multiply pair, averaging and the result register.
// Depends on cnnu_pkg.
module cnnu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cnnu_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  cnnu_pkg::work_t     q_rdata,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output cnnu_pkg::out_item_t out_data
);

  localparam int CW = cnnu_pkg::CTR_W;
  localparam int AC = cnnu_pkg::ACC_W;

  typedef enum logic [2:0] {B_IDLE, B_PROD, B_STEP, B_FIN, B_OUT} bstate_t;

  bstate_t                           state_r;
  logic signed [cnnu_pkg::HELD_W-1:0] held_r;
  logic signed [15:0]                x_r;
  logic                              done_r;
  logic signed [CW-1:0]              center_r;
  logic signed [39:0]                prod_r;
  logic signed [AC-1:0]              acc_r;
  logic [1:0]                        stg_r;
  logic [47:0]                       rec_r;
  logic                              out_v_r;
  cnnu_pkg::out_item_t               out_r;

  logic signed [7:0]                 a4;
  logic signed [16:0]                dt;
  logic signed [39:0]                pcl;
  logic signed [CW:0]                f;
  logic signed [CW+17:0]             kp;
  logic signed [CW-1:0]              k;
  logic signed [CW-1:0]              xs;
  logic signed [CW-1:0]              cnext;
  logic signed [AC-1:0]              acc_nxt;
  logic signed [AC-1:0]              s_sat;
  logic signed [22:0]                u;
  logic [23:0]                       t;
  logic [22:0]                       q;
  logic signed [CW-1:0]              res;
  logic signed [17:0]                rcl;
  logic                              load_out;

  always_comb begin
    a4  = $signed(cfg.a_upper[39:32]);
    dt  = $signed({1'b0, cfg.time_step});
    xs  = CW'(x_r) <<< 4;
    if (prod_r > 40'sd1048576) begin
      pcl = 40'sd1048576;
    end else if (prod_r < -40'sd1048576) begin
      pcl = -40'sd1048576;
    end else begin
      pcl = prod_r;
    end
    f  = (CW+1)'(held_r) + (CW+1)'(pcl >>> 4) - (CW+1)'(center_r);
    kp = f * dt;
    k  = kp[CW+15:16];
    cnext = (stg_r == 2'd2) ? (xs + k) : (xs + (k >>> 1));
    acc_nxt = acc_r + ((stg_r inside {2'd1, 2'd2}) ? (AC'(k) <<< 1) : AC'(k));
    // Past these bounds the final clip wins whatever the center, so the divide stays narrow.
    if (acc_r > 35'sd4194304) begin
      s_sat = 35'sd4194304;
    end else if (acc_r < -35'sd4194304) begin
      s_sat = -35'sd4194304;
    end else begin
      s_sat = acc_r;
    end
    u = s_sat[23:1];
    t = 24'(25'(u) + 25'sd6291456);
    // Floor of the offset value over three, taken from the reciprocal product.
    q   = rec_r[47:25];
    res = xs + $signed(CW'(q)) - 32'sd2097152;
    if (res > 32'sd65536) begin
      rcl = 18'sd65536;
    end else if (res < -32'sd65536) begin
      rcl = -18'sd65536;
    end else begin
      rcl = res[17:0];
    end
    load_out = (state_r == B_OUT) && (!out_v_r || pop);
    q_pop    = (state_r == B_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_v_r <= 1'b0;
    end else begin
      if (pop && out_v_r && !load_out) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            state_r <= B_PROD;
          end
        end
        B_PROD: begin
          state_r <= B_STEP;
        end
        B_STEP: begin
          state_r <= (stg_r == 2'd3) ? B_FIN : B_PROD;
        end
        B_FIN: begin
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (load_out) begin
            out_v_r <= 1'b1;
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
    case (state_r)
      B_IDLE: begin
        held_r   <= q_rdata.held;
        x_r      <= q_rdata.center;
        done_r   <= q_rdata.frame_done;
        center_r <= CW'(q_rdata.center) <<< 4;
        acc_r    <= '0;
        stg_r    <= 2'd0;
      end
      B_PROD: begin
        prod_r <= center_r * a4;
      end
      B_STEP: begin
        center_r <= cnext;
        acc_r    <= acc_nxt;
        stg_r    <= stg_r + 2'd1;
      end
      B_FIN: begin
        rec_r <= t * 24'd11184811;
      end
      B_OUT: begin
        if (load_out) begin
          out_r.next_value <= rcl[17:4];
          out_r.frame_done <= done_r;
        end
      end
      default: begin
        stg_r <= 2'd0;
      end
    endcase
  end

  assign empty    = !out_v_r;
  assign out_data = out_r;

endmodule

>>> design/cnn_template_rk4_cell_update.sv
// Top level of the CNN 3x3 template RK4 cell update: register port, front, queue, back.
// Depends on cnnu_pkg, cnnu_front, cnnu_queue, cnnu_back and assert_macros.svh.
//
//   Port group  Handshake                     Payload
//   in_         push / full                   in_data  (state_value, drive_value)
//   out_        empty / pop                   out_data (next_value, frame_done)
//   cfg         psel penable pwrite / pready  paddr, pwdata, prdata (64 bits)
//
// In the back end each interior cell is loaded, then each RK4 stage takes a product state
// and a step state on the shared center and step multipliers, and the divide by six and
// the result register follow. The front takes one item a cycle into a four stage pipe and
// an eight entry queue, and raises full once pipe and queue items fill the eight entries.
// Reset is synchronous and active low; the line stores are not cleared.
`include "assert_macros.svh"

module cnn_template_rk4_cell_update #(
  parameter int MAX_WIDTH = cnnu_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  cnnu_pkg::in_item_t              in_data,
  output logic                            empty,
  input  logic                            pop,
  output cnnu_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cnnu_pkg::ADDR_W-1:0]     paddr,
  input  logic [cnnu_pkg::DATA_W-1:0]     pwdata,
  output logic [cnnu_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  cnnu_pkg::cfg_t          cfg_r;
  cnnu_pkg::reg_idx_t      reg_sel;
  logic                    wr_en;
  logic                    q_push;
  logic                    q_pop;
  logic                    q_empty;
  logic                    q_full;
  logic [cnnu_pkg::Q_AW:0] q_count;
  cnnu_pkg::work_t         q_wdata;
  cnnu_pkg::work_t         q_rdata;

  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_upper     <= '0;
      cfg_r.a_lower     <= '0;
      cfg_r.b_upper     <= '0;
      cfg_r.b_lower     <= '0;
      cfg_r.bias        <= '0;
      cfg_r.time_step   <= 16'd6554;
      cfg_r.grid_width  <= 11'd1024;
      cfg_r.grid_height <= 13'd4096;
    end else if (wr_en) begin
      case (reg_sel)
        cnnu_pkg::REG_A_UPPER:     cfg_r.a_upper     <= pwdata[47:0];
        cnnu_pkg::REG_A_LOWER:     cfg_r.a_lower     <= pwdata[23:0];
        cnnu_pkg::REG_B_UPPER:     cfg_r.b_upper     <= pwdata[47:0];
        cnnu_pkg::REG_B_LOWER:     cfg_r.b_lower     <= pwdata[23:0];
        cnnu_pkg::REG_BIAS:        cfg_r.bias        <= pwdata[15:0];
        cnnu_pkg::REG_TIME_STEP:   cfg_r.time_step   <= pwdata[15:0];
        cnnu_pkg::REG_GRID_WIDTH:  cfg_r.grid_width  <= pwdata[10:0];
        cnnu_pkg::REG_GRID_HEIGHT: cfg_r.grid_height <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      cnnu_pkg::REG_A_UPPER:     prdata = 64'(cfg_r.a_upper);
      cnnu_pkg::REG_A_LOWER:     prdata = 64'(cfg_r.a_lower);
      cnnu_pkg::REG_B_UPPER:     prdata = 64'(cfg_r.b_upper);
      cnnu_pkg::REG_B_LOWER:     prdata = 64'(cfg_r.b_lower);
      cnnu_pkg::REG_BIAS:        prdata = 64'(cfg_r.bias);
      cnnu_pkg::REG_TIME_STEP:   prdata = 64'(cfg_r.time_step);
      cnnu_pkg::REG_GRID_WIDTH:  prdata = 64'(cfg_r.grid_width);
      cnnu_pkg::REG_GRID_HEIGHT: prdata = 64'(cfg_r.grid_height);
      default:                   prdata = '0;
    endcase
  end

  cnnu_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .cfg     (cfg_r),
    .q_count (q_count),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  cnnu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_count (q_count)
  );

  cnnu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  assign q_full = (q_count == (cnnu_pkg::Q_AW + 1)'(cnnu_pkg::Q_DEPTH));

  `CNNU_ASSERT_IMPL(a_q_no_overflow, q_push, !q_full, "queue written while full")
  `CNNU_ASSERT_IMPL(a_q_no_underflow, q_pop, !q_empty, "queue read while empty")
  `CNNU_ASSERT_NEXT(a_back_one_item, q_pop, !q_pop, "back end took two cells back to back")
  `CNNU_ASSERT_IMPL(a_out_range, !empty, (out_data.next_value >= -14'sd4096) && (out_data.next_value <= 14'sd4096), "result outside plus or minus one")

endmodule
